// ----- design/stw_pkg.sv -----
// Shared types and codes for the spike timing wheel.
`default_nettype none

package stw_pkg;

   // Input item action codes
   localparam logic [1:0] ACT_FORWARD = 2'd0;
   localparam logic [1:0] ACT_RETRO   = 2'd1;
   localparam logic [1:0] ACT_TICK    = 2'd2;

   // Result status codes
   localparam logic [2:0] STATUS_ACCEPTED  = 3'd0;
   localparam logic [2:0] STATUS_RANGE     = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_DELIVERED = 3'd3;
   localparam logic [2:0] STATUS_EMPTY     = 3'd4;

   localparam int PENDING_OUT_W = 10;

   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        event_time;
      logic [31:0]        target_id;
      logic signed [15:0] temporal_offset;
   } req_type;

   typedef struct packed {
      logic [2:0]                 status;
      logic                       event_kind;
      logic [31:0]                out_target_id;
      logic [31:0]                out_event_time;
      logic signed [15:0]         out_temporal_offset;
      logic                       last;
      logic [PENDING_OUT_W-1:0]   pending_count;
   } rsp_type;

   // One stored event in a bucket slot
   typedef struct packed {
      logic               kind;
      logic [31:0]        target_id;
      logic [31:0]        event_time;
      logic signed [15:0] temporal_offset;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_ADDR,
      ST_SCHED,
      ST_TICK,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

// ----- design/spike_timing_wheel_core.sv -----
// Spike timing wheel: circular bucket scheduler for forward and retrograde events.
// Schedule item: steps DIV (multiply), ADDR (fill read), SCHED (fill write, result registered);
//   out of range: result registered in the DIV step.
// Tick item: empty slice gives one result from the TICK state; else DRAIN delivers the slice's
//   events, one per cycle while the output is not stalled. Input is stalled until an item is done.
// Reset: a clearing pass zeroes the bucket fill RAM, input stalled meanwhile.
`default_nettype none

module spike_timing_wheel_core #(
   parameter int SLICES     = 16,
   parameter int BUCKET_CAP = 32,
   parameter int STEP_UNITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  stw_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output stw_pkg::rsp_type rsp_data
);

   import stw_pkg::*;

   localparam int SPAN        = SLICES * STEP_UNITS;
   localparam int DIFF_W      = $clog2(SPAN);
   localparam int SLICE_W     = $clog2(SLICES);
   localparam int SLOT_W      = (BUCKET_CAP > 1) ? $clog2(BUCKET_CAP) : 1;
   localparam int FILL_W      = $clog2(BUCKET_CAP + 1);
   localparam int ENTRY_AW    = SLICE_W + SLOT_W;
   localparam int ENTRY_DEPTH = SLICES * (2 ** SLOT_W);
   localparam int PEND_W      = $clog2(SLICES * BUCKET_CAP + 1);
   localparam int ENTRY_W     = $bits(entry_type);

   // control state
   state_type            state_ff, state_in;
   logic [SLICE_W-1:0]   clear_cnt_ff, clear_cnt_in;
   logic [31:0]          now_ff;
   logic [31:0]          now_plus_ff;
   logic [SLICE_W-1:0]   slice_ptr_ff;
   logic [PEND_W-1:0]    pending_ff, pending_in;
   logic [SLOT_W-1:0]    cnt_ff, cnt_in;
   logic [FILL_W-1:0]    n_ff;
   logic                 rsp_valid_ff, rsp_valid_in;

   // item payload registers
   req_type              req_ff;
   logic [DIFF_W-1:0]    diff_ff, diff_in;
   logic                 in_range_ff, in_range_in;
   logic [31:0]          when_ff, when_in;
   logic [SLICE_W-1:0]   bucket_ff, bucket_in;
   rsp_type              rsp_data_ff, rsp_next;

   // datapath
   logic                 accept;
   logic                 out_free;
   logic                 rsp_load;
   logic                 advance;
   logic [32:0]          diff_raw;
   logic                 clamp;
   logic [32:0]          now_sum;
   logic [31:0]          now_plus_sat;
   logic [SLICE_W-1:0]   rel;
   logic [SLICE_W:0]     bucket_sum;
   logic                 drain_last;

   // memories
   logic                 fill_we;
   logic [SLICE_W-1:0]   fill_wa;
   logic [FILL_W-1:0]    fill_wd;
   logic [SLICE_W-1:0]   fill_ra;
   logic [FILL_W-1:0]    fill_rd;
   logic                 entry_we;
   logic [ENTRY_AW-1:0]  entry_wa;
   logic [ENTRY_AW-1:0]  entry_ra;
   logic [SLOT_W-1:0]    entry_slot_ra;
   entry_type            entry_wd;
   entry_type            entry_rd;
   logic [ENTRY_W-1:0]   entry_rd_vec;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // clamp to one step ahead and find the distance in time units
   assign diff_raw    = {1'b0, req_data.event_time} - {1'b0, now_ff};
   assign clamp       = diff_raw[32] || (diff_raw[31:0] < 32'(STEP_UNITS));
   assign in_range_in = clamp || (diff_raw[31:0] < 32'(SPAN));
   assign diff_in     = clamp ? DIFF_W'(STEP_UNITS) : diff_raw[DIFF_W-1:0];
   assign when_in     = clamp ? now_plus_ff : req_data.event_time;

   // next step time, saturating
   assign now_sum      = {1'b0, now_plus_ff} + 33'(STEP_UNITS);
   assign now_plus_sat = now_sum[32] ? 32'hFFFF_FFFF : now_sum[31:0];

   stw_offset_calc #(
      .SLICES     (SLICES),
      .STEP_UNITS (STEP_UNITS)
   ) u_offset (
      .clock  (clock),
      .enable (state_ff == ST_DIV),
      .diff   (diff_ff),
      .rel    (rel)
   );

   // target bucket: pointer plus offset, wrapped
   assign bucket_sum = {1'b0, slice_ptr_ff} + {1'b0, rel};
   assign bucket_in  = (bucket_sum >= (SLICE_W + 1)'(SLICES))
                       ? SLICE_W'(bucket_sum - (SLICE_W + 1)'(SLICES))
                       : bucket_sum[SLICE_W-1:0];

   // fill RAM read address: keep it steady while a state waits
   always_comb begin
      priority if (state_ff == ST_ADDR) begin
         fill_ra = bucket_in;
      end else if (state_ff == ST_SCHED) begin
         fill_ra = bucket_ff;
      end else begin
         fill_ra = slice_ptr_ff;
      end
   end

   stw_ram #(
      .WIDTH (FILL_W),
      .DEPTH (SLICES)
   ) u_fill_ram (
      .clock   (clock),
      .wr_en   (fill_we),
      .wr_addr (fill_wa),
      .wr_data (fill_wd),
      .rd_addr (fill_ra),
      .rd_data (fill_rd)
   );

   // entry RAM: row per slice, column per slot
   always_comb begin
      priority if (state_ff == ST_TICK) begin
         entry_slot_ra = '0;
      end else if (state_ff == ST_DRAIN && out_free) begin
         entry_slot_ra = cnt_ff + SLOT_W'(1);
      end else begin
         entry_slot_ra = cnt_ff;
      end
   end

   assign entry_ra = {slice_ptr_ff, entry_slot_ra};
   assign entry_wa = {bucket_ff, fill_rd[SLOT_W-1:0]};

   assign entry_wd.kind            = (req_ff.action == ACT_RETRO);
   assign entry_wd.target_id       = req_ff.target_id;
   assign entry_wd.event_time      = when_ff;
   assign entry_wd.temporal_offset = (req_ff.action == ACT_RETRO)
                                     ? req_ff.temporal_offset : 16'sd0;

   stw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRY_DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (entry_wa),
      .wr_data (entry_wd),
      .rd_addr (entry_ra),
      .rd_data (entry_rd_vec)
   );

   assign entry_rd   = entry_type'(entry_rd_vec);
   assign drain_last = (FILL_W'(cnt_ff) == n_ff - FILL_W'(1));

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      pending_in   = pending_ff;
      cnt_in       = cnt_ff;
      rsp_load     = 1'b0;
      rsp_next     = '0;
      advance      = 1'b0;
      fill_we      = 1'b0;
      fill_wa      = slice_ptr_ff;
      fill_wd      = '0;
      entry_we     = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            fill_we      = 1'b1;
            fill_wa      = clear_cnt_ff;
            clear_cnt_in = clear_cnt_ff + SLICE_W'(1);
            if (clear_cnt_ff == SLICE_W'(SLICES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.action)
                  ACT_FORWARD, ACT_RETRO: state_in = ST_DIV;
                  ACT_TICK:               state_in = ST_TICK;
                  default:                state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (!in_range_ff) begin
               if (out_free) begin
                  rsp_load        = 1'b1;
                  rsp_next.status = STATUS_RANGE;
                  rsp_next.last   = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: begin
            state_in = ST_SCHED;
         end
         ST_SCHED: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               rsp_next.last = 1'b1;
               if (fill_rd >= FILL_W'(BUCKET_CAP)) begin
                  rsp_next.status = STATUS_FULL;
               end else begin
                  rsp_next.status = STATUS_ACCEPTED;
                  fill_we         = 1'b1;
                  fill_wa         = bucket_ff;
                  fill_wd         = fill_rd + FILL_W'(1);
                  entry_we        = 1'b1;
                  pending_in      = pending_ff + PEND_W'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_TICK: begin
            if (fill_rd == '0) begin
               if (out_free) begin
                  rsp_load        = 1'b1;
                  rsp_next.status = STATUS_EMPTY;
                  rsp_next.last   = 1'b1;
                  advance         = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_load                     = 1'b1;
               rsp_next.status              = STATUS_DELIVERED;
               rsp_next.event_kind          = entry_rd.kind;
               rsp_next.out_target_id       = entry_rd.target_id;
               rsp_next.out_event_time      = entry_rd.event_time;
               rsp_next.out_temporal_offset = entry_rd.temporal_offset;
               rsp_next.last                = drain_last;
               pending_in                   = pending_ff - PEND_W'(1);
               if (drain_last) begin
                  fill_we  = 1'b1;
                  fill_wa  = slice_ptr_ff;
                  fill_wd  = '0;
                  advance  = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff + SLOT_W'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_next.pending_count = PENDING_OUT_W'(pending_in);
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
         now_ff       <= '0;
         now_plus_ff  <= 32'(STEP_UNITS);
         slice_ptr_ff <= '0;
         pending_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         pending_ff   <= pending_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            now_ff       <= now_plus_ff;
            now_plus_ff  <= now_plus_sat;
            slice_ptr_ff <= (slice_ptr_ff == SLICE_W'(SLICES - 1))
                            ? '0 : slice_ptr_ff + SLICE_W'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff      <= req_data;
         diff_ff     <= diff_in;
         in_range_ff <= in_range_in;
         when_ff     <= when_in;
      end
      if (state_ff == ST_ADDR) begin
         bucket_ff <= bucket_in;
      end
      if (state_ff == ST_TICK) begin
         n_ff <= fill_rd;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/stw_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`default_nettype none

module stw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/stw_offset_calc.sv -----
// Slice offset: distance in time units divided by the step size, by reciprocal multiply.
`default_nettype none

module stw_offset_calc #(
   parameter int SLICES     = 16,
   parameter int STEP_UNITS = 16,
   localparam int SPAN    = SLICES * STEP_UNITS,
   localparam int DIFF_W  = $clog2(SPAN),
   localparam int SLICE_W = $clog2(SLICES)
) (
   input  logic               clock,
   input  logic               enable,
   input  logic [DIFF_W-1:0]  diff,
   output logic [SLICE_W-1:0] rel
);

   // exact for every diff below 2**DIFF_W: m = ceil(2**(N+l) / d)
   localparam int SHIFT_L = $clog2(STEP_UNITS);
   localparam int K       = DIFF_W + SHIFT_L;
   localparam int RECIP   = ((1 << K) + STEP_UNITS - 1) / STEP_UNITS;
   localparam int RECIP_W = K + 1;
   localparam int PROD_W  = DIFF_W + RECIP_W;

   logic [PROD_W-1:0]  product;
   logic [SLICE_W-1:0] rel_ff;

   assign product = PROD_W'(diff) * PROD_W'(RECIP);

   // quotient register; always below SLICES when the distance is in range
   always_ff @(posedge clock) begin
      if (enable) begin
         rel_ff <= product[K +: SLICE_W];
      end
   end

   assign rel = rel_ff;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the spike timing wheel core.
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stw_pkg::*;

   localparam int SLICES       = 16;
   localparam int BUCKET_CAP   = 32;
   localparam int STEP_UNITS   = 16;
   localparam int QUIET_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 32;
   localparam int DUE_DEPTH    = 256;

   // Action code that the block ignores
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Shadow copy of the wheel
   logic [31:0] wheel_now   = '0;
   logic [3:0]  wheel_ptr   = '0;
   int unsigned bucket_len [SLICES];
   entry_type   bucket_slot [SLICES][BUCKET_CAP];
   int unsigned events_held = 0;

   // Ring of results still due, oldest at due_rd
   rsp_type        due_results [DUE_DEPTH];
   int             due_wr          = 0;
   int             due_rd          = 0;
   int             mismatch_count  = 0;
   int             burst_left      = 0;
   int             quiet_cycles    = 0;
   stall_mode_type stall_mode      = STALL_NONE;
   int             stall_mode_left = 0;

   always #2 clock = ~clock;

   spike_timing_wheel_core #(
      .SLICES     (SLICES),
      .BUCKET_CAP (BUCKET_CAP),
      .STEP_UNITS (STEP_UNITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Append one result to the due ring
   task automatic add_due(input rsp_type r);
      due_results[due_wr % DUE_DEPTH] = r;
      due_wr++;
   endtask

   // Update the shadow wheel with one accepted item and queue the results it causes
   task automatic apply_to_wheel(input req_type item);
      logic [32:0] earliest;
      logic [32:0] when_t;
      logic [32:0] rel;
      int          b;
      rsp_type     r;
      entry_type   e;
      begin
         r = '0;
         case (item.action)
            ACT_FORWARD, ACT_RETRO: begin
               // clamp to one step ahead, then pick the slice
               earliest = {1'b0, wheel_now} + 33'(STEP_UNITS);
               when_t   = ({1'b0, item.event_time} < earliest) ? earliest
                                                               : {1'b0, item.event_time};
               rel      = (when_t - {1'b0, wheel_now}) / 33'(STEP_UNITS);
               r.last   = 1'b1;
               if (rel >= 33'(SLICES)) begin
                  r.status = STATUS_RANGE;
               end else begin
                  b = (int'(wheel_ptr) + int'(rel)) % SLICES;
                  if (bucket_len[b] >= BUCKET_CAP) begin
                     r.status = STATUS_FULL;
                  end else begin
                     e.kind            = (item.action == ACT_RETRO);
                     e.target_id       = item.target_id;
                     e.event_time      = when_t[32] ? 32'hFFFF_FFFF : when_t[31:0];
                     e.temporal_offset = (item.action == ACT_RETRO) ? item.temporal_offset
                                                                    : 16'sd0;
                     bucket_slot[b][bucket_len[b]] = e;
                     bucket_len[b]++;
                     events_held++;
                     r.status = STATUS_ACCEPTED;
                  end
               end
               r.pending_count = PENDING_OUT_W'(events_held);
               add_due(r);
            end
            ACT_TICK: begin
               b = int'(wheel_ptr);
               if (bucket_len[b] == 0) begin
                  r.status        = STATUS_EMPTY;
                  r.last          = 1'b1;
                  r.pending_count = PENDING_OUT_W'(events_held);
                  add_due(r);
               end else begin
                  // drain in insertion order
                  for (int i = 0; i < int'(bucket_len[b]); i++) begin
                     e = bucket_slot[b][i];
                     if (events_held > 0) events_held--;
                     r.status              = STATUS_DELIVERED;
                     r.event_kind          = e.kind;
                     r.out_target_id       = e.target_id;
                     r.out_event_time      = e.event_time;
                     r.out_temporal_offset = e.temporal_offset;
                     r.last                = (i == int'(bucket_len[b]) - 1);
                     r.pending_count       = PENDING_OUT_W'(events_held);
                     add_due(r);
                  end
               end
               bucket_len[b] = 0;
               wheel_now = (wheel_now > 32'hFFFF_FFFF - STEP_UNITS) ? 32'hFFFF_FFFF
                                                                    : wheel_now + STEP_UNITS;
               wheel_ptr = wheel_ptr + 4'd1;
            end
            default: ; // unused code: no result, no state change
         endcase
      end
   endtask

   // Drive one item at the falling edge, hold it until accepted; bursts with random gaps
   task automatic offer_item(input req_type item);
      int gap;
      begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
            if (gap > 0) begin
               req_valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 30);
         end
         burst_left--;
         req_valid <= 1'b1;
         req_data  <= item;
         do @(posedge clock); while (req_stall !== 1'b0);
         apply_to_wheel(item);
         @(negedge clock);
      end
   endtask

   // Hold the sender until every queued result has come back
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      burst_left = 0;
      while (due_wr != due_rd) @(negedge clock);
   endtask

   function automatic req_type make_item(logic [1:0] act, logic [31:0] t, logic [31:0] id,
                                         logic [15:0] offs);
      req_type it;
      it.action          = act;
      it.event_time      = t;
      it.target_id       = id;
      it.temporal_offset = offs;
      return it;
   endfunction

   // Ticks, unused codes and schedules: mostly in range of the current time; some past, hot-slice, wild
   function automatic req_type rand_item(int tick_pct, int hot_slice);
      req_type it;
      int      pick;
      it = make_item(ACT_FORWARD, $urandom, $urandom, 16'($urandom));
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
         it.action = ACT_UNUSED;
      end else if (pick < 3 + tick_pct) begin
         it.action = ACT_TICK;
      end else begin
         it.action = $urandom_range(0, 1) ? ACT_RETRO : ACT_FORWARD;
         pick = $urandom_range(0, 99);
         if (pick < 55)
            it.event_time = wheel_now
                          + 32'($urandom_range(0, STEP_UNITS * SLICES + STEP_UNITS));
         else if (pick < 80)
            it.event_time = wheel_now + 32'(STEP_UNITS * hot_slice)
                          + 32'($urandom_range(0, STEP_UNITS - 1));
         else if (pick < 90)
            it.event_time = wheel_now - 32'($urandom_range(0, 64));
      end
      return it;
   endfunction

   // Extremes of each field, clamping, range edges, unused action, then a full revolution
   task automatic test_directed();
      offer_item(make_item(ACT_TICK, '0, '0, '0));
      offer_item(make_item(ACT_FORWARD, '0, '0, 16'h7FFF));
      offer_item(make_item(ACT_RETRO, wheel_now + 32'(STEP_UNITS * SLICES - 1), '1, 16'h8000));
      offer_item(make_item(ACT_FORWARD, wheel_now + 32'(STEP_UNITS * SLICES), 32'h1, '0));
      offer_item(make_item(ACT_RETRO, '1, 32'h8000_0000, 16'h0001));
      offer_item(make_item(ACT_FORWARD, wheel_now + 32'(STEP_UNITS), 32'hA5A5_5A5A, 16'hFFFF));
      offer_item(make_item(ACT_RETRO, wheel_now + 32'(2 * STEP_UNITS - 1), 32'h5A5A_A5A5,
                           16'h7FFF));
      offer_item(make_item(ACT_FORWARD, wheel_now + 32'(STEP_UNITS - 1), 32'hFFFF_0000, '0));
      offer_item(make_item(ACT_UNUSED, '1, '1, '1));
      repeat (SLICES) offer_item(make_item(ACT_TICK, '0, '0, '0));
   endtask

   // Overfill one slice, then tick through it
   task automatic test_bucket_full();
      logic [31:0] hot;
      hot = wheel_now + 32'(3 * STEP_UNITS);
      repeat (BUCKET_CAP + 2)
         offer_item(make_item($urandom_range(0, 1) ? ACT_RETRO : ACT_FORWARD,
                              hot + 32'($urandom_range(0, STEP_UNITS - 1)),
                              $urandom, 16'($urandom)));
      repeat (5) offer_item(make_item(ACT_TICK, $urandom, $urandom, 16'($urandom)));
   endtask

   // Phases with varying tick density and a hot slice; some phases end by waiting for every result
   task automatic test_random();
      int      phase;
      int      sent;
      int      tick_pct;
      int      hot;
      req_type it;
      for (phase = 0; phase < 10; phase++) begin
         tick_pct = $urandom_range(2, 50);
         hot      = $urandom_range(1, SLICES - 1);
         sent     = 0;
         while (sent < 50) begin
            it = rand_item(tick_pct, hot);
            offer_item(it);
            if (it.action != ACT_UNUSED) sent++;
         end
         if (phase % 3 == 1) wait_results_drained();
      end
   endtask

   // Receiver stall pattern: modes of random length
   always @(negedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode      <= stall_mode_type'($urandom_range(0, 3));
         stall_mode_left <= $urandom_range(20, 150);
      end else begin
         stall_mode_left <= stall_mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each accepted result with the oldest one due
   always @(posedge clock) begin : check_results
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (due_wr == due_rd) begin
            $error("result with nothing due: %p", rsp_data);
            mismatch_count++;
         end else begin
            want = due_results[due_rd % DUE_DEPTH];
            due_rd++;
            check_field("status", want.status, rsp_data.status);
            check_field("event_kind", want.event_kind, rsp_data.event_kind);
            check_field("out_target_id", want.out_target_id, rsp_data.out_target_id);
            check_field("out_event_time", want.out_event_time, rsp_data.out_event_time);
            check_field("out_temporal_offset", want.out_temporal_offset,
                        rsp_data.out_temporal_offset);
            check_field("last", want.last, rsp_data.last);
            check_field("pending_count", want.pending_count, rsp_data.pending_count);
         end
      end
   end

   // Watchdog: too long with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < SLICES; i++) bucket_len[i] = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_bucket_full();
      test_random();
      wait_results_drained();
      repeat (SETTLE_TICKS) @(negedge clock);
      if (mismatch_count == 0 && due_wr == due_rd)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

`default_nettype wire
